FILE: rtl/core/olid_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olid_pkg
// Shared types and constants for the ordered list core: transaction payloads,
// operation and status codes.
// ----------------------------------------------------------------------------
package olid_pkg;

  localparam int unsigned DEPTH_DEF = 16;
  localparam int unsigned VALUE_W   = 32;
  localparam int unsigned COUNT_W   = 5;

  typedef enum logic [1:0] {
    MODE_PUSH_FRONT = 2'd0,
    MODE_PUSH_BACK  = 2'd1,
    MODE_DELETE     = 2'd2,
    MODE_NONE       = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_FULL = 2'd1,
    ST_MISS = 2'd2
  } status_e;

  typedef struct packed {
    mode_e                      mode;
    logic signed [VALUE_W-1:0]  value;
  } req_t;

  typedef struct packed {
    status_e                    status;
    logic        [COUNT_W-1:0]  entry_count;
    logic signed [VALUE_W-1:0]  front_value;
    logic signed [VALUE_W-1:0]  back_value;
  } rsp_t;

endpackage

FILE: rtl/core/olid_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olid_mem
// Entry storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module olid_mem #(
  parameter int unsigned DEPTH = olid_pkg::DEPTH_DEF,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                             clk_i,
  input  logic                             wr_en_i,
  input  logic [AW-1:0]                    wr_addr_i,
  input  logic [olid_pkg::VALUE_W-1:0]     wr_data_i,
  input  logic [AW-1:0]                    rd_addr_i,
  output logic [olid_pkg::VALUE_W-1:0]     rd_data_o
);

  logic [olid_pkg::VALUE_W-1:0] mem_q [DEPTH];
  logic [olid_pkg::VALUE_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: rtl/core/ordered_list_insert_delete_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_list_insert_delete_core
// Ordered list of signed values held as a circular buffer in a synchronous
// memory: push front, push back, delete first match by value.
// ----------------------------------------------------------------------------
//  channel   handshake            payload
//  request   start / busy         req_i  (mode, value)
//  result    done_o (strobe)      rsp_o  (status, entry_count, front, back)
//
//  Pushes and no-ops step through S_FRONT, S_BACK and S_FIN to the strobe.
//  A delete scans one entry per cycle through the memory read port, then
//  closes the gap one entry per cycle from the match on.
//  Front and back are read back from the memory before each result.
//  Reset clears the count and head pointer; the storage itself needs none.
//  done_o is high for one cycle and cannot be held off by the receiver.
// ----------------------------------------------------------------------------
module ordered_list_insert_delete_core #(
  parameter int unsigned DEPTH = olid_pkg::DEPTH_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  olid_pkg::req_t req_i,
  output logic           done_o,
  output olid_pkg::rsp_t rsp_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = AW + 2;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SEARCH = 6'b000010,
    S_SHIFT  = 6'b000100,
    S_FRONT  = 6'b001000,
    S_BACK   = 6'b010000,
    S_FIN    = 6'b100000
  } state_e;

  // list position to memory address
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                         input logic [CW-1:0] pos);
    logic [SW-1:0] sum;
    sum = SW'(head) + SW'(pos);
    if (sum >= SW'(DEPTH)) begin
      sum = sum - SW'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  state_e                            state_q, state_d;
  logic [AW-1:0]                     head_q, head_d;
  logic [CW-1:0]                     count_q, count_d;
  logic [CW-1:0]                     rp_q, rp_d;
  logic [CW-1:0]                     cpos_q, cpos_d;
  logic [CW-1:0]                     wpos_q, wpos_d;
  logic                              chk_q, chk_d;
  logic                              shv_q, shv_d;
  logic                              done_q, done_d;
  logic [olid_pkg::VALUE_W-1:0]      key_q, key_d;
  logic [olid_pkg::VALUE_W-1:0]      front_q, front_d;
  olid_pkg::status_e                 status_q, status_d;
  olid_pkg::rsp_t                    rsp_q, rsp_d;

  logic                              mem_we;
  logic [AW-1:0]                     mem_waddr;
  logic [olid_pkg::VALUE_W-1:0]      mem_wdata;
  logic [AW-1:0]                     mem_raddr;
  logic [olid_pkg::VALUE_W-1:0]      mem_rdata;

  logic                              accept;
  logic                              full;
  logic [AW-1:0]                     head_dec;
  logic [CW+olid_pkg::COUNT_W-1:0]   cnt_ext;

  assign busy     = (state_q != S_IDLE);
  assign accept   = start && !busy;
  assign full     = (count_q == CW'(DEPTH));
  assign head_dec = (head_q == '0) ? AW'(DEPTH - 1) : head_q - 1'b1;
  assign cnt_ext  = {{olid_pkg::COUNT_W{1'b0}}, count_q};

  olid_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (mem_we),
    .wr_addr_i (mem_waddr),
    .wr_data_i (mem_wdata),
    .rd_addr_i (mem_raddr),
    .rd_data_o (mem_rdata)
  );

  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    count_d   = count_q;
    rp_d      = rp_q;
    cpos_d    = cpos_q;
    wpos_d    = wpos_q;
    chk_d     = chk_q;
    shv_d     = shv_q;
    key_d     = key_q;
    front_d   = front_q;
    status_d  = status_q;
    rsp_d     = rsp_q;
    done_d    = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = head_q;
    mem_wdata = mem_rdata;
    mem_raddr = head_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          key_d    = req_i.value;
          status_d = olid_pkg::ST_DONE;
          state_d  = S_FRONT;
          unique case (req_i.mode)
            olid_pkg::MODE_PUSH_FRONT: begin
              if (full) begin
                status_d = olid_pkg::ST_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = head_dec;
                mem_wdata = req_i.value;
                head_d    = head_dec;
                count_d   = count_q + 1'b1;
              end
            end
            olid_pkg::MODE_PUSH_BACK: begin
              if (full) begin
                status_d = olid_pkg::ST_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = phys(head_q, count_q);
                mem_wdata = req_i.value;
                count_d   = count_q + 1'b1;
              end
            end
            olid_pkg::MODE_DELETE: begin
              if (count_q == '0) begin
                status_d = olid_pkg::ST_MISS;
              end else begin
                rp_d    = '0;
                chk_d   = 1'b0;
                state_d = S_SEARCH;
              end
            end
            olid_pkg::MODE_NONE: begin
              status_d = olid_pkg::ST_DONE;
            end
          endcase
        end
      end

      // reads issued back to back; each compare falls in the cycle after its read address
      S_SEARCH: begin
        mem_raddr = phys(head_q, rp_q);
        chk_d     = (rp_q < count_q);
        cpos_d    = rp_q;
        if (rp_q < count_q) begin
          rp_d = rp_q + 1'b1;
        end
        priority if (chk_q && (mem_rdata == key_q)) begin
          rp_d    = cpos_q + 1'b1;
          shv_d   = 1'b0;
          chk_d   = 1'b0;
          state_d = S_SHIFT;
        end else if (chk_q && (cpos_q == count_q - 1'b1)) begin
          status_d = olid_pkg::ST_MISS;
          chk_d    = 1'b0;
          state_d  = S_FRONT;
        end
      end

      // read position p, write it back to p-1 on the next cycle
      S_SHIFT: begin
        mem_raddr = phys(head_q, rp_q);
        if (shv_q) begin
          mem_we    = 1'b1;
          mem_waddr = phys(head_q, wpos_q);
          mem_wdata = mem_rdata;
        end
        if (rp_q < count_q) begin
          shv_d  = 1'b1;
          wpos_d = rp_q - 1'b1;
          rp_d   = rp_q + 1'b1;
        end else begin
          shv_d   = 1'b0;
          count_d = count_q - 1'b1;
          state_d = S_FRONT;
        end
      end

      S_FRONT: begin
        mem_raddr = head_q;
        state_d   = S_BACK;
      end

      S_BACK: begin
        mem_raddr = phys(head_q, count_q - 1'b1);
        front_d   = mem_rdata;
        state_d   = S_FIN;
      end

      S_FIN: begin
        rsp_d.status      = status_q;
        rsp_d.entry_count = cnt_ext[olid_pkg::COUNT_W-1:0];
        rsp_d.front_value = (count_q == '0) ? '0 : front_q;
        rsp_d.back_value  = (count_q == '0) ? '0 : mem_rdata;
        done_d            = 1'b1;
        state_d           = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= '0;
      count_q <= '0;
      rp_q    <= '0;
      cpos_q  <= '0;
      wpos_q  <= '0;
      chk_q   <= 1'b0;
      shv_q   <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      count_q <= count_d;
      rp_q    <= rp_d;
      cpos_q  <= cpos_d;
      wpos_q  <= wpos_d;
      chk_q   <= chk_d;
      shv_q   <= shv_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q    <= key_d;
    front_q  <= front_d;
    status_q <= status_d;
    rsp_q    <= rsp_d;
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

`ifndef SYNTHESIS
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("entry count beyond depth");

  a_write_phase : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == S_IDLE) || (state_q == S_SHIFT))
    else $error("memory write outside push or gap close");

  a_done_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy && $past(state_q == S_FIN))
    else $error("result strobe not after finish");

  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("accepted transaction did not raise busy");
`endif

endmodule
